>>> hdl/ctwsd_pkg.sv
// shared types and constants for the crank trigger wheel sync decoder
// no dependencies
`default_nettype none
package ctwsd_pkg;
  localparam logic [2:0] MODE_INIT      = 3'd0;
  localparam logic [2:0] MODE_ASYNC     = 3'd1;
  localparam logic [2:0] MODE_ASYNC_KEY = 3'd2;
  localparam logic [2:0] MODE_ASYNC_GAP = 3'd3;
  localparam logic [2:0] MODE_SYNC      = 3'd4;

  localparam logic [1:0] SENSE_KEY_BEGIN = 2'd0;
  localparam logic [1:0] SENSE_KEY_END   = 2'd1;
  localparam logic [1:0] SENSE_INVERT    = 2'd2;
  localparam logic [1:0] SENSE_NONE      = 2'd3;

  localparam logic [1:0] REG_RATIO_MIN = 2'd0;
  localparam logic [1:0] REG_RATIO_MAX = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_TICK      = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic div_start;   // start ratio division
    logic acc_start;   // start period multiply
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic ratio_ok;
    logic acc_done;
  } stat_t;
endpackage
`default_nettype wire

>>> hdl/ctwsd_datapath.sv
// datapath: bit-serial ratio divider and shift-add period multiplier
// depends on ctwsd_pkg
`default_nettype none
module ctwsd_datapath #(
  parameter int INTERVAL_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctwsd_pkg::cmd_t          cmd,
  output ctwsd_pkg::stat_t              stat,
  input  wire logic [INTERVAL_BITS-1:0] key_len,
  input  wire logic [INTERVAL_BITS-1:0] gap_len,
  input  wire logic [6:0]               ratio_min,
  input  wire logic [6:0]               ratio_max,
  input  wire logic [INTERVAL_BITS+4:0] sum_in,
  input  wire logic [6:0]               half_tick,
  output logic [31:0]                   period
);
  localparam int DW = INTERVAL_BITS + 8;  // key*100 width
  localparam int SW = INTERVAL_BITS + 1;  // key+gap width
  localparam int CW = $clog2(DW + 1);

  // restoring divider, one quotient bit per cycle
  logic [DW-1:0] num;
  logic [DW-1:0] quo;
  logic [SW:0]   rem;
  logic [SW-1:0] den;
  logic [CW-1:0] dcnt;
  logic          dbusy;
  logic          div_done;
  logic          zero_in;
  logic [SW:0]   rem_sh;
  logic [SW:0]   rem_sub;

  assign rem_sh  = {rem[SW-1:0], num[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy    <= 1'b0;
      div_done <= 1'b0;
    end else if (cmd.div_start) begin
      num      <= DW'(key_len) * DW'(100);
      den      <= SW'(key_len) + SW'(gap_len);
      zero_in  <= (key_len == '0) || (gap_len == '0);
      rem      <= '0;
      quo      <= '0;
      dcnt     <= CW'(DW);
      dbusy    <= 1'b1;
      div_done <= 1'b0;
    end else if (dbusy) begin
      num <= {num[DW-2:0], 1'b0};
      if (!rem_sub[SW]) begin
        rem <= rem_sub;
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
      dcnt     <= dcnt - CW'(1);
      dbusy    <= (dcnt != CW'(1));
      div_done <= (dcnt == CW'(1));
    end else begin
      div_done <= 1'b0;
    end
  end

  assign stat.div_done = div_done;
  assign stat.ratio_ok = !zero_in && (quo >= DW'(ratio_min)) && (quo <= DW'(ratio_max));

  // shift-add multiply, one multiplier bit per cycle
  logic [31:0] mcand;
  logic [6:0]  mplier;
  logic [2:0]  mcnt;
  logic        mbusy;
  logic        acc_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy    <= 1'b0;
      acc_done <= 1'b0;
      period   <= '0;
    end else if (cmd.acc_start) begin
      mcand    <= 32'(sum_in);
      mplier   <= half_tick;
      period   <= '0;
      mcnt     <= 3'd7;
      mbusy    <= 1'b1;
      acc_done <= 1'b0;
    end else if (mbusy) begin
      if (mplier[0]) period <= period + mcand;
      mcand    <= {mcand[30:0], 1'b0};
      mplier   <= {1'b0, mplier[6:1]};
      mcnt     <= mcnt - 3'd1;
      mbusy    <= (mcnt != 3'd1);
      acc_done <= (mcnt == 3'd1);
    end else begin
      acc_done <= 1'b0;
    end
  end

  assign stat.acc_done = acc_done;
endmodule
`default_nettype wire

>>> hdl/crank_trigger_wheel_sync_decoder.sv
// top level: crank trigger wheel decoder controller, config registers, handshakes
// depends on ctwsd_pkg and ctwsd_datapath
`default_nettype none
// Crank trigger wheel decoder with key/gap ratio sync. Each input word is a
// crank edge (func 0) or a timer overflow tick (func 1); each gives exactly
// one result word. An overflow tick and most edges pass from accept through
// the execute state to the output state and the result register. An edge that
// checks the key ratio (async_gap, or sync at B1) runs the serial divider,
// INTERVAL_BITS+8 quotient steps, before its result; an edge that completes
// a cycle of 2*POSITIONS_PER_TURN intervals runs the 7-step shift-add period
// multiply. The longest path is a check at B1 together with the period update,
// which runs the divider and then the multiply. One word is handled at a
// time; the result sits in an output register while the next word is taken,
// and a new result is held back only while the previous one still waits.
module crank_trigger_wheel_sync_decoder #(
  parameter int POSITIONS_PER_TURN = 8,
  parameter int INTERVAL_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [INTERVAL_BITS-1:0] s_tdata,  // interval
  input  wire logic        s_tuser,               // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // state_code[2:0] position[6:3] sensing_cmd[8:7] start_timer[9] stop_timer[10]
  // export_strobe[11] exported_position[15:12] exported_period_us[47:16]
  // sync_gained[48] sync_lost[49] timed_out[50], zero fill to 56
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int PW = $clog2(POSITIONS_PER_TURN + 1);
  localparam int CCW = $clog2(2 * POSITIONS_PER_TURN + 1);
  localparam int SUMW = INTERVAL_BITS + 5;
  localparam logic [PW-1:0] POS_UNDEF = PW'(POSITIONS_PER_TURN);
  localparam logic [PW-1:0] POS_A2 = PW'(1);
  localparam logic [PW-1:0] POS_B1 = PW'(2);

  // controller states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [6:0]  ratio_min, ratio_max, tick_us_half;
  logic [15:0] timeout_limit;
  logic [7:0]  tick_us;
  assign tick_us_half = tick_us[7:1];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_min     <= 7'd0;
      ratio_max     <= 7'd100;
      timeout_limit <= 16'd10;
      tick_us       <= 8'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        ctwsd_pkg::REG_RATIO_MIN: ratio_min     <= cfg_data[6:0];
        ctwsd_pkg::REG_RATIO_MAX: ratio_max     <= cfg_data[6:0];
        ctwsd_pkg::REG_TIMEOUT:   timeout_limit <= cfg_data;
        default:                  tick_us       <= cfg_data[7:0];
      endcase
    end
  end

  // decoder state
  logic [2:0]  mode;
  logic [PW-1:0] wpos, exp_pos;
  logic [INTERVAL_BITS-1:0] key_len, gap_len, ivl;
  logic [SUMW-1:0] csum;
  logic [CCW-1:0]  ccnt;
  logic [31:0] period_us, exp_period;
  logic [15:0] ovf_cnt;
  logic        func;
  // per-word flags
  logic [1:0] sense;
  logic start_t, stop_t, strobe, gained, lost, tmo;
  logic check_b1, mul_pend;

  ctwsd_pkg::cmd_t  cmd, cmd_next;
  ctwsd_pkg::stat_t stat;
  logic [31:0] mul_out;

  ctwsd_datapath #(.INTERVAL_BITS(INTERVAL_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .key_len(key_len), .gap_len(gap_len),
    .ratio_min(ratio_min), .ratio_max(ratio_max),
    .sum_in(csum), .half_tick(tick_us_half), .period(mul_out)
  );

  // input is taken whenever the controller is idle; a waiting result
  // only holds the controller in ST_OUT
  assign s_tready = (state == ST_IDLE);

  logic out_load;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  logic [PW-1:0] pos_inc;
  logic [SUMW-1:0] sum_add;
  logic cyc_wrap;
  assign pos_inc = (wpos >= PW'(POSITIONS_PER_TURN - 1)) ? '0 : wpos + PW'(1);
  assign sum_add = csum + SUMW'(ivl);
  assign cyc_wrap = (ccnt + CCW'(1)) >= CCW'(2 * POSITIONS_PER_TURN);

  // datapath commands, one-cycle pulses
  always_comb begin
    cmd_next = '0;
    if (state == ST_EXEC && !func) begin
      if (mode == ctwsd_pkg::MODE_ASYNC_GAP) begin
        cmd_next.div_start = 1'b1;
      end else if (mode == ctwsd_pkg::MODE_SYNC) begin
        if (pos_inc == POS_B1) cmd_next.div_start = 1'b1;
        else if (cyc_wrap) cmd_next.acc_start = 1'b1;
      end
    end else if (state == ST_DIV && stat.div_done && check_b1 && stat.ratio_ok
                 && mul_pend) begin
      cmd_next.acc_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; m_tvalid <= 1'b0; cmd <= '0;
      mode <= ctwsd_pkg::MODE_INIT; wpos <= POS_UNDEF; exp_pos <= POS_UNDEF;
      key_len <= '0; gap_len <= '0; csum <= '0; ccnt <= '0;
      period_us <= '0; exp_period <= '0; ovf_cnt <= '0;
    end else begin
      cmd <= cmd_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          func <= s_tuser; ivl <= s_tdata; state <= ST_EXEC;
        end
        ST_EXEC: begin
          gained <= 1'b0; lost <= 1'b0;
          if (func) begin
            sense <= ctwsd_pkg::SENSE_NONE; start_t <= 1'b0;
            check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_OUT;
            if (ovf_cnt >= timeout_limit) begin
              mode <= ctwsd_pkg::MODE_INIT; wpos <= POS_UNDEF;
              key_len <= '0; gap_len <= '0; csum <= '0; ccnt <= '0;
              period_us <= '0; exp_period <= '0; exp_pos <= POS_UNDEF;
              stop_t <= 1'b1; tmo <= 1'b1; strobe <= 1'b1;
            end else begin
              ovf_cnt <= ovf_cnt + 16'd1;
              stop_t <= 1'b0; tmo <= 1'b0; strobe <= 1'b0;
            end
          end else begin
            ovf_cnt <= '0; stop_t <= 1'b0; tmo <= 1'b0;
            start_t <= (mode == ctwsd_pkg::MODE_INIT);
            unique case (mode)
              ctwsd_pkg::MODE_INIT: begin
                sense <= ctwsd_pkg::SENSE_KEY_BEGIN;
                mode <= ctwsd_pkg::MODE_ASYNC; wpos <= POS_UNDEF;
                key_len <= '0; gap_len <= '0; csum <= '0; ccnt <= '0;
                period_us <= '0;
                strobe <= 1'b0; check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_OUT;
              end
              ctwsd_pkg::MODE_ASYNC: begin
                sense <= ctwsd_pkg::SENSE_KEY_END; mode <= ctwsd_pkg::MODE_ASYNC_KEY;
                strobe <= 1'b0; check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_OUT;
              end
              ctwsd_pkg::MODE_ASYNC_KEY: begin
                key_len <= ivl; sense <= ctwsd_pkg::SENSE_KEY_BEGIN;
                mode <= ctwsd_pkg::MODE_ASYNC_GAP;
                strobe <= 1'b0; check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_OUT;
              end
              ctwsd_pkg::MODE_ASYNC_GAP: begin
                gap_len <= ivl; sense <= ctwsd_pkg::SENSE_KEY_END;
                strobe <= 1'b0; check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_DIV;
              end
              ctwsd_pkg::MODE_SYNC: begin
                wpos <= pos_inc; sense <= ctwsd_pkg::SENSE_INVERT;
                csum <= sum_add;
                ccnt <= cyc_wrap ? '0 : ccnt + CCW'(1);
                mul_pend <= cyc_wrap;
                check_b1 <= (pos_inc == POS_B1);
                if (pos_inc == POS_A2) key_len <= ivl;
                if (pos_inc == POS_B1) begin
                  gap_len <= ivl; strobe <= 1'b0; state <= ST_DIV;
                end else if (cyc_wrap) begin
                  strobe <= 1'b0; state <= ST_MUL;
                end else begin
                  exp_pos <= pos_inc; exp_period <= period_us; strobe <= 1'b1;
                  state <= ST_OUT;
                end
              end
              default: begin
                mode <= ctwsd_pkg::MODE_INIT; sense <= ctwsd_pkg::SENSE_NONE;
                strobe <= 1'b0; check_b1 <= 1'b0; mul_pend <= 1'b0; state <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: if (stat.div_done) begin
          if (check_b1) begin
            if (!stat.ratio_ok) begin
              wpos <= POS_UNDEF; key_len <= '0; gap_len <= '0; csum <= '0;
              ccnt <= '0; period_us <= '0; mode <= ctwsd_pkg::MODE_INIT;
              lost <= 1'b1; state <= ST_OUT;
            end else if (mul_pend) begin
              state <= ST_MUL;
            end else begin
              exp_pos <= wpos; exp_period <= period_us; strobe <= 1'b1;
              state <= ST_OUT;
            end
          end else begin
            if (stat.ratio_ok) begin
              mode <= ctwsd_pkg::MODE_SYNC; wpos <= POS_B1; gained <= 1'b1;
              exp_pos <= POS_B1; exp_period <= period_us; strobe <= 1'b1;
            end else begin
              mode <= ctwsd_pkg::MODE_ASYNC_KEY; wpos <= POS_UNDEF;
              key_len <= '0; gap_len <= '0; csum <= '0; ccnt <= '0;
              period_us <= '0;
            end
            state <= ST_OUT;
          end
        end
        ST_MUL: if (stat.acc_done) begin
          period_us <= mul_out; csum <= '0;
          exp_pos <= wpos; exp_period <= mul_out; strobe <= 1'b1;
          state <= ST_OUT;
        end
        // wait here only while the previous result is still unaccepted
        ST_OUT: if (out_load) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, tmo, lost, gained, exp_period, 4'(exp_pos), strobe,
                  stop_t, start_t, sense, 4'(wpos), mode};
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accepted while busy");
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (mode == ctwsd_pkg::MODE_SYNC) |-> (wpos != POS_UNDEF))
    else $error("sync without position");
  a_out_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> m_tvalid) else $error("result not presented");
endmodule
`default_nettype wire
